FILE: src/tcal_pkg.sv
// shared types and constants of the time-of-day counter with alarm latch
// no dependencies; imported by the interfaces, the serial units and the top level
package tcal_pkg;

    localparam int AMT_W     = 16;
    localparam int DIVISOR_W = 16;
    localparam int SUM_W     = 17;
    localparam int BYTE_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int WIDE_W    = 32;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_PULSE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    localparam logic [1:0] SEL_LOW   = 2'd0;
    localparam logic [1:0] SEL_MID   = 2'd1;
    localparam logic [1:0] SEL_HIGH  = 2'd2;
    localparam logic [1:0] SEL_OTHER = 2'd3;

    localparam logic [WIDE_W-1:0] KEEP_LOW  = 32'h00FF_FF00;
    localparam logic [WIDE_W-1:0] KEEP_MID  = 32'h00FF_00FF;
    localparam logic [WIDE_W-1:0] KEEP_HIGH = 32'h0000_FFFF;
    localparam logic [WIDE_W-1:0] ALARM_RST = 32'h0000_FFFF;

    localparam logic [BYTE_W-1:0] OTHER_READ = 8'hFF;

    typedef struct packed {
        logic                 done;
        logic [SUM_W-1:0]     quot;
        logic [DIVISOR_W-1:0] rem;
    } div_res_t;

    typedef struct packed {
        logic done;
        logic hit;
    } adv_stat_t;

endpackage

FILE: src/tcal_req_if.sv
// request channel: valid/ready handshake carrying one request word
// depends on tcal_pkg
interface tcal_req_if import tcal_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [AMT_W-1:0]  amount;
    logic [1:0]        reg_sel;
    logic [BYTE_W-1:0] write_data;
    logic              write_to_alarm;

    modport source (
        output valid,
        output req_type,
        output amount,
        output reg_sel,
        output write_data,
        output write_to_alarm,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  amount,
        input  reg_sel,
        input  write_data,
        input  write_to_alarm,
        output ready
    );

endinterface

FILE: src/tcal_rsp_if.sv
// response channel: valid/ready handshake carrying one response word
// depends on tcal_pkg
interface tcal_rsp_if import tcal_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              alarm_hit;

    modport source (
        output valid,
        output read_data,
        output alarm_hit,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_data,
        input  alarm_hit,
        output ready
    );

endinterface

FILE: src/tod_counter_with_alarm_latch.sv
// time-of-day counter with alarm compare and read latch, top level
// depends on tcal_pkg, tcal_req_if, tcal_rsp_if, tcal_div, tcal_adv
// tick word: the divider runs, then the digit-serial advance, then the result waits in S_DONE
// pulse word: advance only; read, write and no-op words go straight to S_DONE
// one word in flight (req.ready only in S_IDLE); S_DONE waits for a free output register
// rst_n clears count, latch and run state, alarm to 0x00FFFF, divisor to 0
module tod_counter_with_alarm_latch import tcal_pkg::*; #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tcal_req_if.sink             req,
    tcal_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [DIVISOR_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ADV,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIVISOR_W-1:0]   tpi_reg, tpi_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] alarm_reg, alarm_next;
    logic [COUNT_WIDTH-1:0] latched_reg, latched_next;
    logic                   latch_on_reg, latch_on_next;
    logic                   stopped_reg, stopped_next;
    logic [DIVISOR_W-1:0]   prem_reg, prem_next;
    logic [BYTE_W-1:0]      res_data_reg, res_data_next;
    logic                   res_hit_reg, res_hit_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      out_data_reg, out_data_next;
    logic                   out_hit_reg, out_hit_next;

    logic                   accept;
    logic                   out_free;
    logic                   div_start;
    logic [SUM_W-1:0]       dividend;
    div_res_t               div_res;
    logic                   adv_start;
    logic [SUM_W-1:0]       adv_steps;
    logic [COUNT_WIDTH-1:0] adv_count;
    adv_stat_t              adv_stat;
    logic [COUNT_WIDTH-1:0] wr_tgt;
    logic [COUNT_WIDTH-1:0] wr_val;
    logic [WIDE_W-1:0]      tgt_wide;
    logic [WIDE_W-1:0]      cnt_wide;
    logic [WIDE_W-1:0]      lat_wide;

    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.alarm_hit = out_hit_reg;

    assign dividend  = {1'b0, prem_reg} + {1'b0, req.amount};
    assign adv_steps = (state_reg == S_DIV) ? div_res.quot : SUM_W'(req.amount);

    tcal_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (tpi_reg),
        .res      (div_res)
    );

    tcal_adv #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_adv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (adv_start),
        .count_in  (count_reg),
        .alarm_in  (alarm_reg),
        .steps     (adv_steps),
        .count_out (adv_count),
        .stat      (adv_stat)
    );

    always_comb
    begin
        wr_tgt   = req.write_to_alarm ? alarm_reg : count_reg;
        tgt_wide = WIDE_W'(wr_tgt);
        cnt_wide = WIDE_W'(count_reg);
        lat_wide = WIDE_W'(latched_reg);
        case (req.reg_sel)
            SEL_LOW:
                wr_val = COUNT_WIDTH'((tgt_wide & KEEP_LOW) | WIDE_W'(req.write_data));
            SEL_MID:
                wr_val = COUNT_WIDTH'((tgt_wide & KEEP_MID)
                                      | (WIDE_W'(req.write_data) << BYTE_W));
            SEL_HIGH:
                wr_val = COUNT_WIDTH'((tgt_wide & KEEP_HIGH)
                                      | (WIDE_W'(req.write_data) << (2 * BYTE_W)));
            default:
                wr_val = wr_tgt;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        tpi_next      = cfg_we ? cfg_wdata : tpi_reg;
        count_next    = count_reg;
        alarm_next    = alarm_reg;
        latched_next  = latched_reg;
        latch_on_next = latch_on_reg;
        stopped_next  = stopped_reg;
        prem_next     = prem_reg;
        res_data_next = res_data_reg;
        res_hit_next  = res_hit_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next = out_data_reg;
        out_hit_next  = out_hit_reg;
        div_start     = 1'b0;
        adv_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_data_next = '0;
                    res_hit_next  = 1'b0;
                    state_next    = S_DONE;
                    case (req.req_type)
                        REQ_TICK:
                        begin
                            if ((req.amount != '0) && (tpi_reg != '0) && !stopped_reg)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        REQ_PULSE:
                        begin
                            if (req.amount != '0)
                            begin
                                adv_start  = 1'b1;
                                state_next = S_ADV;
                            end
                        end
                        REQ_READ:
                        begin
                            case (req.reg_sel)
                                SEL_LOW:
                                begin
                                    if (latch_on_reg)
                                    begin
                                        res_data_next = lat_wide[BYTE_W-1:0];
                                        latch_on_next = 1'b0;
                                    end
                                    else
                                    begin
                                        res_data_next = cnt_wide[BYTE_W-1:0];
                                    end
                                end
                                SEL_MID:
                                    res_data_next = latch_on_reg ? lat_wide[2*BYTE_W-1:BYTE_W]
                                                                 : cnt_wide[2*BYTE_W-1:BYTE_W];
                                SEL_HIGH:
                                begin
                                    latched_next  = count_reg;
                                    latch_on_next = 1'b1;
                                    res_data_next = cnt_wide[3*BYTE_W-1:2*BYTE_W];
                                end
                                SEL_OTHER:
                                    res_data_next = OTHER_READ;
                                default:
                                    res_data_next = OTHER_READ;
                            endcase
                        end
                        REQ_WRITE:
                        begin
                            if (req.write_to_alarm)
                            begin
                                alarm_next = wr_val;
                            end
                            else
                            begin
                                count_next   = wr_val;
                                stopped_next = (req.reg_sel != SEL_LOW);
                            end
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    prem_next  = div_res.rem;
                    adv_start  = 1'b1;
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                if (adv_stat.done)
                begin
                    count_next   = adv_count;
                    res_hit_next = adv_stat.hit;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_hit_next   = res_hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tpi_reg       <= '0;
            count_reg     <= '0;
            alarm_reg     <= COUNT_WIDTH'(ALARM_RST);
            latched_reg   <= '0;
            latch_on_reg  <= 1'b0;
            stopped_reg   <= 1'b0;
            prem_reg      <= '0;
            res_data_reg  <= '0;
            res_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tpi_reg       <= tpi_next;
            count_reg     <= count_next;
            alarm_reg     <= alarm_next;
            latched_reg   <= latched_next;
            latch_on_reg  <= latch_on_next;
            stopped_reg   <= stopped_next;
            prem_reg      <= prem_next;
            res_data_reg  <= res_data_next;
            res_hit_reg   <= res_hit_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_hit_reg   <= out_hit_next;
        end
    end

    // divider and advance unit only report completion in their own phase
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        adv_stat.done |-> (state_reg == S_ADV))
        else $error("advance done outside advance phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (rsp.valid && state_reg == S_IDLE))
        else $error("finished word not moved to output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> ($stable(stopped_reg) && $stable(alarm_reg)))
        else $error("run state or alarm changed while a word is in flight");

endmodule

FILE: src/tcal_div.sv
// bit-serial restoring divider for the prescaler, one quotient bit per cycle
// depends on tcal_pkg
module tcal_div import tcal_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output div_res_t             res
);

    localparam int STEPS = SUM_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIVISOR_W-1:0] rem_reg,  rem_next;
    logic [SUM_W-1:0]     quot_reg, quot_next;
    logic [DIVISOR_W-1:0] dsr_reg,  dsr_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 take;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[SUM_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        take      = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quot_next = {quot_reg[SUM_W-2:0], take};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

FILE: src/tcal_adv.sv
// digit-serial counter advance: adds the step count and checks whether any
// step lands on the alarm, four bits per cycle, lsb first; depends on tcal_pkg
module tcal_adv import tcal_pkg::*; #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] count_in,
    input  logic [COUNT_WIDTH-1:0] alarm_in,
    input  logic [SUM_W-1:0]       steps,
    output logic [COUNT_WIDTH-1:0] count_out,
    output adv_stat_t              stat
);

    localparam int SPAN   = (COUNT_WIDTH > SUM_W) ? COUNT_WIDTH : SUM_W;
    localparam int NDIG   = (SPAN + DIGIT_W - 1) / DIGIT_W;
    localparam int LEN    = NDIG * DIGIT_W;
    localparam int CNT_W  = $clog2(NDIG + 1);

    logic [LEN-1:0]   c_sh_reg, c_sh_next;
    logic [LEN-1:0]   a_sh_reg, a_sh_next;
    logic [LEN-1:0]   n_sh_reg, n_sh_next;
    logic [LEN-1:0]   m_sh_reg, m_sh_next;
    logic             cy_sum_reg, cy_sum_next;
    logic             cy_dist_reg, cy_dist_next;
    logic             lt_reg, lt_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIGIT_W-1:0] c_d, a_d, n_d, m_d;
    logic [DIGIT_W:0]   sum;
    logic [DIGIT_W:0]   dsum;
    logic [DIGIT_W-1:0] sum_dig;
    logic [DIGIT_W-1:0] dist_dig;

    always_comb
    begin
        c_d      = c_sh_reg[DIGIT_W-1:0];
        a_d      = a_sh_reg[DIGIT_W-1:0];
        n_d      = n_sh_reg[DIGIT_W-1:0];
        m_d      = m_sh_reg[DIGIT_W-1:0];
        // count + steps, and alarm - count - 1 as alarm + ~count
        sum      = {1'b0, c_d} + {1'b0, n_d} + {{DIGIT_W{1'b0}}, cy_sum_reg};
        dsum     = {1'b0, a_d} + {1'b0, ~c_d} + {{DIGIT_W{1'b0}}, cy_dist_reg};
        sum_dig  = sum[DIGIT_W-1:0] & m_d;
        dist_dig = dsum[DIGIT_W-1:0] & m_d;

        c_sh_next    = c_sh_reg;
        a_sh_next    = a_sh_reg;
        n_sh_next    = n_sh_reg;
        m_sh_next    = m_sh_reg;
        cy_sum_next  = cy_sum_reg;
        cy_dist_next = cy_dist_reg;
        lt_next      = lt_reg;
        left_next    = left_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start)
        begin
            c_sh_next    = LEN'(count_in);
            a_sh_next    = LEN'(alarm_in);
            n_sh_next    = LEN'(steps);
            m_sh_next    = LEN'({COUNT_WIDTH{1'b1}});
            cy_sum_next  = 1'b0;
            cy_dist_next = 1'b0;
            lt_next      = 1'b0;
            left_next    = CNT_W'(NDIG);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            c_sh_next    = {sum_dig, c_sh_reg[LEN-1:DIGIT_W]};
            a_sh_next    = {{DIGIT_W{1'b0}}, a_sh_reg[LEN-1:DIGIT_W]};
            n_sh_next    = {{DIGIT_W{1'b0}}, n_sh_reg[LEN-1:DIGIT_W]};
            m_sh_next    = {{DIGIT_W{1'b0}}, m_sh_reg[LEN-1:DIGIT_W]};
            cy_sum_next  = sum[DIGIT_W];
            cy_dist_next = dsum[DIGIT_W];
            // lsb-first magnitude compare: distance below step count
            lt_next      = (dist_dig < n_d) || ((dist_dig == n_d) && lt_reg);
            left_next    = left_reg - 1'b1;
            if (left_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_sh_reg    <= c_sh_next;
        a_sh_reg    <= a_sh_next;
        n_sh_reg    <= n_sh_next;
        m_sh_reg    <= m_sh_next;
        cy_sum_reg  <= cy_sum_next;
        cy_dist_reg <= cy_dist_next;
        lt_reg      <= lt_next;
    end

    assign count_out = c_sh_reg[COUNT_WIDTH-1:0];
    assign stat.done = done_reg;
    assign stat.hit  = lt_reg;

endmodule

FILE: dv/tod_result_check.sv
// result checker for tod_counter_with_alarm_latch: tracks counter, alarm, latch and prescaler
// state from accepted request words and config writes, compares every response word in order
// depends on tcal_pkg, tcal_req_if, tcal_rsp_if
module tod_result_check import tcal_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    tcal_req_if                  req,
    tcal_rsp_if                  rsp,
    input  logic                 cfg_we,
    input  logic [DIVISOR_W-1:0] cfg_wdata,
    output int                   mismatches,
    output int                   in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_W = 24;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              alarm_hit;
    } tod_result_t;

    logic [COUNT_W-1:0]   count_q;
    logic [COUNT_W-1:0]   alarm_q;
    logic [COUNT_W-1:0]   latch_q;
    logic                 latch_on;
    logic                 halted;
    logic [SUM_W-1:0]     prescale;
    logic [DIVISOR_W-1:0] divisor;
    tod_result_t          pending_results[$];
    int                   errors = 0;

    function automatic logic bump_count(input logic [WIDE_W-1:0] steps);
        logic [COUNT_W-1:0] gap_left;
        logic               hit;
        gap_left = alarm_q - count_q - 1'b1;
        hit = (steps != 0) && ({{(WIDE_W-COUNT_W){1'b0}}, gap_left} < steps);
        count_q = count_q + steps[COUNT_W-1:0];
        return hit;
    endfunction

    function automatic tod_result_t apply_word(
        input logic [1:0]        kind,
        input logic [AMT_W-1:0]  amt,
        input logic [1:0]        sel,
        input logic [BYTE_W-1:0] data,
        input logic              to_alarm
    );
        tod_result_t        res;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] tgt;
        logic [COUNT_W-1:0] view;
        res = '0;
        case (kind)
            REQ_TICK:
            begin
                if (amt != 0 && divisor != 0 && !halted)
                begin
                    sum = prescale + {1'b0, amt};
                    if (sum >= {1'b0, divisor})
                    begin
                        res.alarm_hit = bump_count(WIDE_W'(sum / divisor));
                        sum = sum % divisor;
                    end
                    prescale = sum;
                end
            end
            REQ_PULSE:
            begin
                if (amt != 0)
                    res.alarm_hit = bump_count(WIDE_W'(amt));
            end
            REQ_READ:
            begin
                view = latch_on ? latch_q : count_q;
                case (sel)
                    SEL_LOW:
                    begin
                        res.read_data = view[7:0];
                        latch_on = 1'b0;
                    end
                    SEL_MID:
                        res.read_data = view[15:8];
                    SEL_HIGH:
                    begin
                        latch_q = count_q;
                        latch_on = 1'b1;
                        res.read_data = count_q[23:16];
                    end
                    default:
                        res.read_data = OTHER_READ;
                endcase
            end
            default:
            begin
                tgt = to_alarm ? alarm_q : count_q;
                if (!to_alarm)
                    halted = 1'b1;
                case (sel)
                    SEL_LOW:
                    begin
                        tgt = (tgt & KEEP_LOW[COUNT_W-1:0]) | {16'h0, data};
                        if (!to_alarm)
                            halted = 1'b0;
                    end
                    SEL_MID:
                        tgt = (tgt & KEEP_MID[COUNT_W-1:0]) | {8'h0, data, 8'h0};
                    SEL_HIGH:
                        tgt = (tgt & KEEP_HIGH[COUNT_W-1:0]) | {data, 16'h0};
                    default:
                        ;
                endcase
                if (to_alarm)
                    alarm_q = tgt;
                else
                    count_q = tgt;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tod_result_t want;
        logic        bad;
        if (!rst_n)
        begin
            count_q = '0;
            alarm_q = ALARM_RST[COUNT_W-1:0];
            latch_q = '0;
            latch_on = 1'b0;
            halted = 1'b0;
            prescale = '0;
            divisor = '0;
            pending_results.delete();
            in_flight <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_we)
                divisor = cfg_wdata;
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected word read_data=%h alarm_hit=%b",
                             $time, rsp.read_data, rsp.alarm_hit);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    bad = 1'b0;
                    if (rsp.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, rsp.read_data);
                        bad = 1'b1;
                    end
                    if (rsp.alarm_hit !== want.alarm_hit)
                    begin
                        $display("%0t: alarm_hit expected %b actual %b",
                                 $time, want.alarm_hit, rsp.alarm_hit);
                        bad = 1'b1;
                    end
                    if (bad)
                        errors++;
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(apply_word(req.req_type, req.amount, req.reg_sel,
                                                     req.write_data, req.write_to_alarm));
            in_flight <= pending_results.size();
            mismatches <= errors;
        end
    end

endmodule

FILE: dv/testbench.sv
// top of the tod_counter_with_alarm_latch regression: clock, reset, request stimulus,
// divisor programming, response back-pressure and the verdict
// depends on tcal_pkg, tcal_req_if, tcal_rsp_if, tod_result_check and the block itself
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tcal_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [DIVISOR_W-1:0] cfg_wdata;
    int                   mismatches;
    int                   in_flight;
    int                   words_sent = 0;
    bit                   steady = 1'b0;

    tcal_req_if req_ch ();
    tcal_rsp_if rsp_ch ();

    tod_counter_with_alarm_latch u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tod_result_check u_result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 6)
            return AMT_W'($urandom_range(1, 20));
        if (r < 8)
            return AMT_W'($urandom_range(1, 1000));
        return AMT_W'($urandom);
    endfunction

    task automatic send_word(
        input logic [1:0]        kind,
        input logic [AMT_W-1:0]  amt,
        input logic [1:0]        sel,
        input logic [BYTE_W-1:0] data,
        input logic              to_alarm
    );
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.amount         <= amt;
        req_ch.reg_sel        <= sel;
        req_ch.write_data     <= data;
        req_ch.write_to_alarm <= to_alarm;
        do
            @(posedge clk);
        while (!req_ch.ready);
        words_sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic set_divisor(input logic [DIVISOR_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int stall_left;
        int run_left;
        rsp_ch.ready <= 1'b0;
        stall_left = 0;
        run_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0 && !steady)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    stall_left = pick_gap();
                    run_left = $urandom_range(0, 12);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tod_counter_with_alarm_latch regression: fail");
        $finish;
    end

    initial
    begin
        logic [DIVISOR_W-1:0] phase_div [8];
        logic [23:0]          base;
        logic [23:0]          target;
        int                   phase_end;
        int                   guard;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_TICK;
        req_ch.amount         <= '0;
        req_ch.reg_sel        <= SEL_LOW;
        req_ch.write_data     <= '0;
        req_ch.write_to_alarm <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // latch read with the reset divisor, then stop, restart and wrap, then ticks with divisors 1, 0xFFFF and 3
        send_word(REQ_READ, '1, SEL_HIGH, '1, 1'b1);
        send_word(REQ_READ, '0, SEL_MID, '0, 1'b0);
        send_word(REQ_READ, '0, SEL_LOW, '0, 1'b0);
        send_word(REQ_TICK, '1, SEL_LOW, '0, 1'b0);
        send_word(REQ_PULSE, '0, SEL_LOW, '0, 1'b0);
        send_word(REQ_PULSE, '1, SEL_LOW, '0, 1'b0);
        send_word(REQ_READ, '0, SEL_OTHER, '0, 1'b0);
        send_word(REQ_WRITE, '0, SEL_HIGH, 8'hFF, 1'b0);
        send_word(REQ_WRITE, '0, SEL_HIGH, 8'h00, 1'b1);
        send_word(REQ_WRITE, '0, SEL_LOW, 8'h01, 1'b1);
        send_word(REQ_WRITE, '0, SEL_MID, 8'h00, 1'b1);
        send_word(REQ_WRITE, '0, SEL_LOW, 8'hFE, 1'b0);
        send_word(REQ_PULSE, 16'd3, SEL_LOW, '0, 1'b0);
        send_word(REQ_WRITE, '0, SEL_MID, 8'h00, 1'b0);
        send_word(REQ_WRITE, '0, SEL_OTHER, 8'hAA, 1'b1);
        set_divisor(16'd1);
        send_word(REQ_TICK, 16'd5, SEL_LOW, '0, 1'b0);
        send_word(REQ_WRITE, '0, SEL_LOW, 8'h00, 1'b0);
        send_word(REQ_TICK, 16'd1, SEL_LOW, '0, 1'b0);
        set_divisor('1);
        send_word(REQ_TICK, 16'hFFFE, SEL_LOW, '0, 1'b0);
        send_word(REQ_TICK, '0, SEL_LOW, '0, 1'b0);
        set_divisor(16'd3);
        send_word(REQ_TICK, '1, SEL_LOW, '0, 1'b0);
        send_word(REQ_READ, '0, SEL_HIGH, '0, 1'b0);
        send_word(REQ_READ, '0, SEL_LOW, '0, 1'b0);
        send_word(REQ_PULSE, '1, SEL_OTHER, '1, 1'b1);

        phase_div[0] = DIVISOR_W'($urandom_range(1, 8));
        phase_div[1] = '0;
        phase_div[2] = DIVISOR_W'($urandom);
        phase_div[3] = 16'd1;
        phase_div[4] = DIVISOR_W'($urandom_range(2, 40));
        phase_div[5] = '1;
        phase_div[6] = DIVISOR_W'($urandom_range(1, 4));
        phase_div[7] = DIVISOR_W'($urandom_range(1, 200));
        phase_end = words_sent;
        for (int p = 0; p < 8; p++)
        begin
            set_divisor(phase_div[p]);
            steady = (p == 3);
            phase_end += 125;
            while (words_sent < phase_end)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5:
                    begin
                        send_word(REQ_READ, pick_amount(), SEL_HIGH, BYTE_W'($urandom),
                                  1'($urandom));
                        if ($urandom_range(0, 1))
                            send_word(2'($urandom_range(0, 1)), pick_amount(), 2'($urandom),
                                      BYTE_W'($urandom), 1'($urandom));
                        send_word(REQ_READ, pick_amount(), SEL_MID, BYTE_W'($urandom),
                                  1'($urandom));
                        send_word(REQ_READ, pick_amount(), SEL_LOW, BYTE_W'($urandom),
                                  1'($urandom));
                    end
                    6, 7, 8, 9, 10:
                    begin
                        base = 24'($urandom);
                        target = base + 24'($urandom_range(1, 40));
                        send_word(REQ_WRITE, pick_amount(), SEL_HIGH, base[23:16], 1'b0);
                        send_word(REQ_WRITE, pick_amount(), SEL_MID, base[15:8], 1'b0);
                        send_word(REQ_WRITE, pick_amount(), SEL_LOW, base[7:0], 1'b0);
                        send_word(REQ_WRITE, pick_amount(), SEL_MID, target[15:8], 1'b1);
                        send_word(REQ_WRITE, pick_amount(), SEL_HIGH, target[23:16], 1'b1);
                        send_word(REQ_WRITE, pick_amount(), SEL_LOW, target[7:0], 1'b1);
                        repeat ($urandom_range(1, 4))
                            send_word(2'($urandom_range(0, 1)), AMT_W'($urandom_range(1, 30)),
                                      2'($urandom), BYTE_W'($urandom), 1'($urandom));
                    end
                    11, 12, 13:
                    begin
                        send_word(REQ_WRITE, pick_amount(), 2'($urandom_range(1, 3)),
                                  BYTE_W'($urandom), 1'b0);
                        repeat ($urandom_range(1, 3))
                            send_word(2'($urandom_range(0, 1)), pick_amount(), 2'($urandom),
                                      BYTE_W'($urandom), 1'($urandom));
                        send_word(REQ_WRITE, pick_amount(), SEL_LOW, BYTE_W'($urandom), 1'b0);
                    end
                    default:
                        send_word(2'($urandom_range(0, 3)), pick_amount(), 2'($urandom),
                                  BYTE_W'($urandom), 1'($urandom));
                endcase
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end
        steady = 1'b0;

        req_ch.valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (in_flight != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("tod_counter_with_alarm_latch regression: pass");
        else
            $display("tod_counter_with_alarm_latch regression: fail");
        $finish;
    end

endmodule
